>>> design/rrt_pkg.sv
package rrt_pkg;

    localparam int C_W = 24;

    typedef logic signed [C_W-1:0] t_coord;

    localparam int DEF_MAX_NODES   = 4096;
    localparam int DEF_GRID_WIDTH  = 256;
    localparam int DEF_GRID_HEIGHT = 256;

    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_EXTEND = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_ADDED    = 3'd2;
    localparam logic [2:0] ST_GOAL     = 3'd3;
    localparam logic [2:0] ST_POOL     = 3'd4;
    localparam logic [2:0] ST_ITER     = 3'd5;
    localparam logic [2:0] ST_FINISHED = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TOL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd6;

    localparam logic [4:0]  DEF_CELL_SHIFT = 5'd6;
    localparam logic [15:0] DEF_STEP_SIZE  = 16'd205;
    localparam logic [47:0] DEF_GOAL_TOL   = 48'd209715;
    localparam logic [6:0]  DEF_CHECKS     = 7'd4;
    localparam logic [15:0] DEF_MAX_ITER   = 16'd5000;

    localparam t_coord COORD_MIN = 24'sh800000;
    localparam t_coord COORD_MAX = 24'sh7FFFFF;

    // shared divider and square root widths
    localparam int DIV_NW = 44;
    localparam int DIV_DW = 28;
    localparam int SQ_W   = 50;
    localparam int ROOT_W = SQ_W / 2 + 1;

endpackage

>>> design/rrt_ifs.sv
interface rrt_in_if import rrt_pkg::*;;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    t_coord     pos_x;
    t_coord     pos_y;
    t_coord     target_x;
    t_coord     target_y;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic       occupied;

    modport source (output valid, opcode, pos_x, pos_y, target_x, target_y,
                    cell_col, cell_row, occupied, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, target_x, target_y,
                    cell_col, cell_row, occupied, output ready);
endinterface

interface rrt_out_if import rrt_pkg::*;;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] node_index;
    logic [11:0] parent_index;
    t_coord      new_x;
    t_coord      new_y;
    logic [15:0] iterations_used;

    modport source (output valid, status, node_index, parent_index, new_x, new_y,
                    iterations_used, input ready);
    modport sink   (input valid, status, node_index, parent_index, new_x, new_y,
                    iterations_used, output ready);
endinterface

>>> design/rrt_ram.sv
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/rrt_div.sv
// restoring divider, one quotient bit per cycle
module rrt_div import rrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo,
    output logic [DIV_DW-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   sh;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic [DIV_DW-1:0] n_rem;

    always_comb begin
        sh    = {r_rem, r_quo[DIV_NW-1]};
        diff  = sh - {1'b0, r_den};
        ge    = (sh >= {1'b0, r_den});
        n_rem = ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIV_NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> design/rrt_isqrt.sv
// digit-by-digit square root, two radicand bits per cycle, rounded to nearest
module rrt_isqrt import rrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [SQ_W-1:0]   i_val,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] root_rnd;

    assign trial    = r_r + r_bit;
    assign root_rnd = (r_n > r_r) ? r_r + 1'b1 : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_n    <= i_val;
                r_r    <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
            end else if (r_busy) begin
                if (r_n >= trial) begin
                    r_n <= r_n - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == SQ_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = root_rnd[ROOT_W-1:0];

endmodule

>>> design/rrt_tree_extension.sv
// Extend item: scans all N nodes in the tree, then checks the new point and up to n probe points, n = probe count.
// Map, start and other items go straight from accept to the result hand-off.
// One item at a time; the next item is taken while the previous result waits.
// Rate is set by the node scan (one node memory read per cycle), then the
// shared iterative divider (up to 4 divisions) and the square root unit.
// Synchronous active-low reset: config to defaults, empty tree, run finished.
module rrt_tree_extension import rrt_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rrt_in_if.sink                i_item,
    rrt_out_if.source             o_res
);

    localparam int NIDX_W = $clog2(MAX_NODES);
    localparam int NT_W   = $clog2(MAX_NODES + 1);
    localparam int GDEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int NODE_W = 2 * C_W + NIDX_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;   // nearest node search
    localparam logic [3:0] S_PREP  = 4'd2;   // deltas, |d|*step
    localparam logic [3:0] S_SQRT  = 4'd3;   // branch length
    localparam logic [3:0] S_DIVX  = 4'd4;   // x offset
    localparam logic [3:0] S_DIVY  = 4'd5;   // y offset
    localparam logic [3:0] S_OFFS  = 4'd6;   // new point, saturated
    localparam logic [3:0] S_PPRE  = 4'd7;   // probe spacing setup
    localparam logic [3:0] S_PDIVX = 4'd8;
    localparam logic [3:0] S_PDIVY = 4'd9;
    localparam logic [3:0] S_PADDR = 4'd10;  // cell address, grid read
    localparam logic [3:0] S_PCHK  = 4'd11;  // cell check, next probe
    localparam logic [3:0] S_PCALC = 4'd12;  // probe point
    localparam logic [3:0] S_GOAL  = 4'd13;  // insert node, goal distance
    localparam logic [3:0] S_FIN   = 4'd14;  // status priority
    localparam logic [3:0] S_DONE  = 4'd15;  // hand result to output register

    logic [3:0] r_state;

    // configuration
    t_coord      r_org_x;
    t_coord      r_org_y;
    logic [4:0]  r_cshift;
    logic [15:0] r_step;
    logic [47:0] r_gtol;
    logic [6:0]  r_checks;
    logic [15:0] r_maxit;

    // planner state
    logic [NT_W-1:0] r_total;
    logic [15:0]     r_iter;
    logic            r_done;
    t_coord          r_goal_x;
    t_coord          r_goal_y;

    // current extend
    t_coord            r_px;
    t_coord            r_py;
    logic [NT_W-1:0]   r_scan;
    logic              r_v0, r_v1, r_v2;
    logic [NIDX_W-1:0] r_i0, r_i1, r_i2;
    t_coord            r_x1, r_y1, r_x2, r_y2;
    logic signed [24:0] r_dx1, r_dy1;
    logic [49:0]       r_sqx2, r_sqy2;
    logic [50:0]       r_best;
    logic [NIDX_W-1:0] r_pidx;
    t_coord            r_nx, r_ny;
    logic              r_sx, r_sy;
    logic [40:0]       r_mx, r_my;
    logic [ROOT_W-1:0] r_len;
    logic [19:0]       r_qx, r_qy;
    t_coord            r_ox, r_oy;
    logic [25:0]       r_d2y;
    logic [24:0]       r_ax, r_ay;
    logic [7:0]        r_bx, r_by;
    logic [25:0]       r_pqx, r_pqy;
    logic [8:0]        r_prx, r_pry;
    logic [6:0]        r_pi;
    t_coord            r_qpt_x, r_qpt_y;
    logic              r_off;
    logic              r_added;
    logic [NIDX_W-1:0] r_nidx;
    logic [49:0]       r_gsqx, r_gsqy;

    // pending result
    logic [2:0]        r_rst;
    logic [NIDX_W-1:0] r_rnidx;
    logic [NIDX_W-1:0] r_rpidx;
    t_coord            r_rx, r_ry;

    // output register
    logic              r_o_valid;
    logic [2:0]        r_o_status;
    logic [NIDX_W-1:0] r_o_nidx;
    logic [NIDX_W-1:0] r_o_pidx;
    t_coord            r_o_x, r_o_y;
    logic [15:0]       r_o_iter;

    // shared arithmetic units
    logic              r_div_go;
    logic [DIV_NW-1:0] r_div_num;
    logic [DIV_DW-1:0] r_div_den;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_DW-1:0] div_rem;
    logic              r_sq_go;
    logic [SQ_W-1:0]   r_sq_val;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    rrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    rrt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_sq_go),
        .i_val   (r_sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // node store: {parent, x, y}
    logic              node_we;
    logic [NIDX_W-1:0] node_waddr;
    logic [NODE_W-1:0] node_wdata;
    logic [NODE_W-1:0] node_rdata;
    t_coord            node_x, node_y;

    rrt_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_nodes (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (r_scan[NIDX_W-1:0]),
        .o_rdata (node_rdata)
    );

    assign node_x = node_rdata[2*C_W-1:C_W];
    assign node_y = node_rdata[C_W-1:0];

    // occupancy grid, cell (col,row) at col*GRID_HEIGHT + row
    logic            in_acc;
    logic            grid_we;
    logic [GA_W-1:0] grid_waddr;
    logic [GA_W-1:0] grid_raddr;
    logic [0:0]      grid_rdata;

    rrt_ram #(.WIDTH(1), .DEPTH(GDEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (i_item.occupied),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid && (r_state == S_IDLE);

    assign grid_we = in_acc && (i_item.opcode == OP_MAP)
                     && (32'(i_item.cell_col) < 32'(GRID_WIDTH))
                     && (32'(i_item.cell_row) < 32'(GRID_HEIGHT));
    assign grid_waddr = GA_W'(32'(i_item.cell_col) * 32'(GRID_HEIGHT)
                              + 32'(i_item.cell_row));

    always_comb begin
        if (r_state == S_IDLE) begin
            node_we    = in_acc && (i_item.opcode == OP_START);
            node_waddr = '0;
            node_wdata = {NIDX_W'(0), i_item.pos_x, i_item.pos_y};
        end else begin
            node_we    = (r_state == S_GOAL);
            node_waddr = r_total[NIDX_W-1:0];
            node_wdata = {r_pidx, r_ox, r_oy};
        end
    end

    // scan datapath
    logic signed [24:0] sdx, sdy;
    logic signed [49:0] ssq_x, ssq_y;
    logic [50:0]        sd2;

    assign sdx   = {r_px[C_W-1], r_px} - {node_x[C_W-1], node_x};
    assign sdy   = {r_py[C_W-1], r_py} - {node_y[C_W-1], node_y};
    assign ssq_x = r_dx1 * r_dx1;
    assign ssq_y = r_dy1 * r_dy1;
    assign sd2   = {1'b0, r_sqx2} + {1'b0, r_sqy2};

    // step toward the sample
    logic signed [24:0] ndx, ndy;
    logic [23:0]        nmx, nmy;
    logic signed [20:0] offx, offy;
    logic signed [25:0] sumx, sumy;
    t_coord             satx, saty;

    assign ndx  = {r_px[C_W-1], r_px} - {r_nx[C_W-1], r_nx};
    assign ndy  = {r_py[C_W-1], r_py} - {r_ny[C_W-1], r_ny};
    assign nmx  = ndx[24] ? 24'(-ndx) : ndx[23:0];
    assign nmy  = ndy[24] ? 24'(-ndy) : ndy[23:0];
    assign offx = r_sx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
    assign offy = r_sy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
    assign sumx = {{2{r_nx[C_W-1]}}, r_nx} + {{5{offx[20]}}, offx};
    assign sumy = {{2{r_ny[C_W-1]}}, r_ny} + {{5{offy[20]}}, offy};

    always_comb begin
        if (sumx < 26'(COORD_MIN)) satx = COORD_MIN;
        else if (sumx > 26'(COORD_MAX)) satx = COORD_MAX;
        else satx = sumx[C_W-1:0];
        if (sumy < 26'(COORD_MIN)) saty = COORD_MIN;
        else if (sumy > 26'(COORD_MAX)) saty = COORD_MAX;
        else saty = sumy[C_W-1:0];
    end

    // probe spacing: point i = nearest + round(delta*i/n), kept as running
    // quotient and remainder of (2|delta|*i + n) / 2n
    logic [6:0]         nchk;
    logic [7:0]         n2;
    logic signed [24:0] pdx, pdy;
    logic [25:0]        pd2x, pd2y;
    logic [25:0]        nq_x, nq_y;
    logic [8:0]         nr_x, nr_y;
    logic [8:0]         tr_x, tr_y;

    assign nchk = (r_checks == 7'd0) ? 7'd1 : r_checks;
    assign n2   = {nchk, 1'b0};
    assign pdx  = {r_ox[C_W-1], r_ox} - {r_nx[C_W-1], r_nx};
    assign pdy  = {r_oy[C_W-1], r_oy} - {r_ny[C_W-1], r_ny};
    assign pd2x = {(pdx[24] ? 25'(-pdx) : 25'(pdx)), 1'b0};
    assign pd2y = {(pdy[24] ? 25'(-pdy) : 25'(pdy)), 1'b0};

    always_comb begin
        tr_x = r_prx + 9'(r_bx);
        tr_y = r_pry + 9'(r_by);
        nq_x = r_pqx + 26'(r_ax);
        nq_y = r_pqy + 26'(r_ay);
        nr_x = tr_x;
        nr_y = tr_y;
        if (tr_x >= 9'(n2)) begin
            nr_x = tr_x - 9'(n2);
            nq_x = nq_x + 26'd1;
        end
        if (tr_y >= 9'(n2)) begin
            nr_y = tr_y - 9'(n2);
            nq_y = nq_y + 26'd1;
        end
    end

    logic signed [25:0] ppx, ppy;

    assign ppx = {{2{r_nx[C_W-1]}}, r_nx} + (r_sx ? -$signed(r_pqx) : $signed(r_pqx));
    assign ppy = {{2{r_ny[C_W-1]}}, r_ny} + (r_sy ? -$signed(r_pqy) : $signed(r_pqy));

    // cell lookup; points left of or below the origin or past the grid are blocked
    logic signed [24:0] relx, rely;
    logic [23:0]        cx, cy;
    logic               off_grid;

    assign relx     = {r_qpt_x[C_W-1], r_qpt_x} - {r_org_x[C_W-1], r_org_x};
    assign rely     = {r_qpt_y[C_W-1], r_qpt_y} - {r_org_y[C_W-1], r_org_y};
    assign cx       = relx[23:0] >> r_cshift;
    assign cy       = rely[23:0] >> r_cshift;
    assign off_grid = relx[24] || rely[24]
                      || (32'(cx) >= 32'(GRID_WIDTH)) || (32'(cy) >= 32'(GRID_HEIGHT));
    assign grid_raddr = GA_W'(32'(cx) * 32'(GRID_HEIGHT) + 32'(cy));

    // goal distance
    logic signed [24:0] gdx, gdy;
    logic signed [49:0] gsq_x, gsq_y;
    logic [50:0]        gd2;
    logic               pool_full;

    assign gdx       = {r_ox[C_W-1], r_ox} - {r_goal_x[C_W-1], r_goal_x};
    assign gdy       = {r_oy[C_W-1], r_oy} - {r_goal_y[C_W-1], r_goal_y};
    assign gsq_x     = gdx * gdx;
    assign gsq_y     = gdy * gdy;
    assign gd2       = {1'b0, r_gsqx} + {1'b0, r_gsqy};
    assign pool_full = (r_total >= NT_W'(MAX_NODES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_cshift  <= DEF_CELL_SHIFT;
            r_step    <= DEF_STEP_SIZE;
            r_gtol    <= DEF_GOAL_TOL;
            r_checks  <= DEF_CHECKS;
            r_maxit   <= DEF_MAX_ITER;
            r_total   <= '0;
            r_iter    <= '0;
            r_done    <= 1'b1;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_div_go  <= 1'b0;
            r_sq_go   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_X:   r_org_x  <= i_cfg_data[C_W-1:0];
                    CFG_ORIGIN_Y:   r_org_y  <= i_cfg_data[C_W-1:0];
                    CFG_CELL_SHIFT: r_cshift <= i_cfg_data[4:0];
                    CFG_STEP_SIZE:  r_step   <= i_cfg_data[15:0];
                    CFG_GOAL_TOL:   r_gtol   <= i_cfg_data[47:0];
                    CFG_CHECKS:     r_checks <= i_cfg_data[6:0];
                    CFG_MAX_ITER:   r_maxit  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (o_res.valid && o_res.ready) begin
                r_o_valid <= 1'b0;
            end

            // nearest-node pipeline: read, delta, square, compare
            r_v0 <= (r_state == S_SCAN) && (r_scan < r_total);
            r_i0 <= r_scan[NIDX_W-1:0];
            if ((r_state == S_SCAN) && (r_scan < r_total)) begin
                r_scan <= r_scan + 1'b1;
            end
            r_v1   <= r_v0;
            r_i1   <= r_i0;
            r_x1   <= node_x;
            r_y1   <= node_y;
            r_dx1  <= sdx;
            r_dy1  <= sdy;
            r_v2   <= r_v1;
            r_i2   <= r_i1;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_sqx2 <= $unsigned(ssq_x);
            r_sqy2 <= $unsigned(ssq_y);
            // strict compare keeps the lowest index on ties
            if (r_v2 && (sd2 < r_best)) begin
                r_best <= sd2;
                r_pidx <= r_i2;
                r_nx   <= r_x2;
                r_ny   <= r_y2;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_rst   <= ST_OK;
                        r_rnidx <= '0;
                        r_rpidx <= '0;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_state <= S_DONE;
                        case (i_item.opcode)
                            OP_START: begin
                                r_total  <= NT_W'(1);
                                r_iter   <= '0;
                                r_done   <= 1'b0;
                                r_goal_x <= i_item.target_x;
                                r_goal_y <= i_item.target_y;
                                r_rx     <= i_item.pos_x;
                                r_ry     <= i_item.pos_y;
                            end
                            OP_EXTEND: begin
                                if (r_done) begin
                                    r_rst <= ST_FINISHED;
                                end else if (r_iter >= r_maxit) begin
                                    r_rst  <= ST_ITER;
                                    r_done <= 1'b1;
                                end else begin
                                    r_iter  <= r_iter + 1'b1;
                                    r_px    <= i_item.pos_x;
                                    r_py    <= i_item.pos_y;
                                    r_scan  <= '0;
                                    r_best  <= '1;
                                    r_pidx  <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_SCAN: begin
                    if ((r_scan == r_total) && !r_v0 && !r_v1 && !r_v2) begin
                        r_state <= S_PREP;
                    end
                end

                S_PREP: begin
                    r_mx <= 41'(nmx) * 41'(r_step);
                    r_my <= 41'(nmy) * 41'(r_step);
                    if (r_best == '0) begin
                        // sample on the nearest node: step in +x
                        r_qx    <= 20'(r_step);
                        r_qy    <= '0;
                        r_sx    <= 1'b0;
                        r_sy    <= 1'b0;
                        r_state <= S_OFFS;
                    end else begin
                        r_sx     <= ndx[24];
                        r_sy     <= ndy[24];
                        r_sq_go  <= 1'b1;
                        r_sq_val <= r_best[SQ_W-1:0];
                        r_state  <= S_SQRT;
                    end
                end

                S_SQRT: begin
                    if (sq_done) begin
                        r_len     <= sq_root;
                        r_div_go  <= 1'b1;
                        r_div_num <= (DIV_NW'(r_mx) << 1) + DIV_NW'(sq_root);
                        r_div_den <= DIV_DW'(sq_root) << 1;
                        r_state   <= S_DIVX;
                    end
                end

                S_DIVX: begin
                    if (div_done) begin
                        r_qx      <= div_quo[19:0];
                        r_div_go  <= 1'b1;
                        r_div_num <= (DIV_NW'(r_my) << 1) + DIV_NW'(r_len);
                        r_div_den <= DIV_DW'(r_len) << 1;
                        r_state   <= S_DIVY;
                    end
                end

                S_DIVY: begin
                    if (div_done) begin
                        r_qy    <= div_quo[19:0];
                        r_state <= S_OFFS;
                    end
                end

                S_OFFS: begin
                    r_ox    <= satx;
                    r_oy    <= saty;
                    r_state <= S_PPRE;
                end

                S_PPRE: begin
                    r_sx      <= pdx[24];
                    r_sy      <= pdy[24];
                    r_d2y     <= pd2y;
                    r_div_go  <= 1'b1;
                    r_div_num <= DIV_NW'(pd2x);
                    r_div_den <= DIV_DW'(n2);
                    r_state   <= S_PDIVX;
                end

                S_PDIVX: begin
                    if (div_done) begin
                        r_ax      <= div_quo[24:0];
                        r_bx      <= div_rem[7:0];
                        r_div_go  <= 1'b1;
                        r_div_num <= DIV_NW'(r_d2y);
                        r_div_den <= DIV_DW'(n2);
                        r_state   <= S_PDIVY;
                    end
                end

                S_PDIVY: begin
                    if (div_done) begin
                        r_ay    <= div_quo[24:0];
                        r_by    <= div_rem[7:0];
                        r_pqx   <= '0;
                        r_pqy   <= '0;
                        r_prx   <= 9'(nchk);
                        r_pry   <= 9'(nchk);
                        r_pi    <= '0;
                        // the new point itself is checked first
                        r_qpt_x <= r_ox;
                        r_qpt_y <= r_oy;
                        r_state <= S_PADDR;
                    end
                end

                S_PADDR: begin
                    r_off   <= off_grid;
                    r_state <= S_PCHK;
                end

                S_PCHK: begin
                    if (r_off || grid_rdata[0]) begin
                        r_added <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_pi == nchk) begin
                        r_state <= S_GOAL;
                    end else begin
                        r_pqx   <= nq_x;
                        r_pqy   <= nq_y;
                        r_prx   <= nr_x;
                        r_pry   <= nr_y;
                        r_pi    <= r_pi + 1'b1;
                        r_state <= S_PCALC;
                    end
                end

                S_PCALC: begin
                    r_qpt_x <= ppx[C_W-1:0];
                    r_qpt_y <= ppy[C_W-1:0];
                    r_state <= S_PADDR;
                end

                S_GOAL: begin
                    r_added <= 1'b1;
                    r_nidx  <= r_total[NIDX_W-1:0];
                    r_total <= r_total + 1'b1;
                    r_gsqx  <= $unsigned(gsq_x);
                    r_gsqy  <= $unsigned(gsq_y);
                    r_state <= S_FIN;
                end

                S_FIN: begin
                    r_rpidx <= r_pidx;
                    r_rx    <= r_ox;
                    r_ry    <= r_oy;
                    r_rnidx <= r_added ? r_nidx : '0;
                    // goal, then pool full, then iteration limit
                    if (r_added && (gd2 < {3'b000, r_gtol})) begin
                        r_rst  <= ST_GOAL;
                        r_done <= 1'b1;
                    end else if (r_added && pool_full) begin
                        r_rst  <= ST_POOL;
                        r_done <= 1'b1;
                    end else if (r_iter >= r_maxit) begin
                        r_rst  <= ST_ITER;
                        r_done <= 1'b1;
                    end else begin
                        r_rst <= r_added ? ST_ADDED : ST_BLOCKED;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_rst;
                        r_o_nidx   <= r_rnidx;
                        r_o_pidx   <= r_rpidx;
                        r_o_x      <= r_rx;
                        r_o_y      <= r_ry;
                        r_o_iter   <= r_iter;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [31:0] o_nidx32, o_pidx32;

    assign o_nidx32 = 32'(r_o_nidx);
    assign o_pidx32 = 32'(r_o_pidx);

    assign o_res.valid           = r_o_valid;
    assign o_res.status          = r_o_status;
    assign o_res.node_index      = o_nidx32[11:0];
    assign o_res.parent_index    = o_pidx32[11:0];
    assign o_res.new_x           = r_o_x;
    assign o_res.new_y           = r_o_y;
    assign o_res.iterations_used = r_o_iter;

`ifndef SYNTH
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= NT_W'(MAX_NODES))
        else $error("node count beyond pool size");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item accepted while busy");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVX || r_state == S_DIVY
                      || r_state == S_PDIVX || r_state == S_PDIVY))
        else $error("divider result with no consumer");

    a_run_has_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> (r_total != '0))
        else $error("active run with empty tree");
`endif

endmodule

>>> verif/rrt_tree_checker.sv
`timescale 1ns / 100ps

module rrt_tree_checker import rrt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rrt_in_if                     i_item,
    rrt_out_if                    i_res,
    output int                    o_fails,
    output int                    o_pending
);

    typedef struct {
        logic [2:0]  status;
        logic [11:0] node;
        logic [11:0] parent;
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] iters;
    } t_branch;

    t_branch branch_q[$];

    // mirror of the planner state
    bit              occ_map [0:65535];
    longint          tree_x [0:4095];
    longint          tree_y [0:4095];
    int unsigned     tree_total;
    int unsigned     iter_cnt;
    bit              run_over;
    longint          goal_x, goal_y;

    longint          org_x, org_y;
    int unsigned     shift_cfg, step_cfg, probes_cfg, iter_lim;
    longint unsigned tol_cfg;

    int fails;

    function automatic longint unsigned root_round(longint unsigned v);
        longint unsigned r, b, n;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        n = v;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    // halves away from zero
    function automatic longint div_round(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp24(longint v);
        if (v < -64'sd8388608) return -64'sd8388608;
        if (v > 64'sd8388607) return 64'sd8388607;
        return v;
    endfunction

    function automatic longint unsigned dist_sq(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // off-grid counts as blocked
    function automatic bit cell_open(longint x, longint y);
        longint rx, ry, cx, cy;
        rx = x - org_x;
        ry = y - org_y;
        if (rx < 0 || ry < 0) return 1'b0;
        cx = rx >>> shift_cfg;
        cy = ry >>> shift_cfg;
        if (cx >= 256 || cy >= 256) return 1'b0;
        return !occ_map[cx * 256 + cy];
    endfunction

    function automatic longint sx24(logic [23:0] v);
        return longint'($signed(v));
    endfunction

    task automatic predict_branch();
        t_branch         e;
        longint          px, py, nx, ny, ox, oy, offx, offy, qx, qy;
        longint unsigned best, d2, len;
        int unsigned     pidx, nidx, n;
        bit              clear;
        px = sx24(i_item.pos_x);
        py = sx24(i_item.pos_y);
        e.status = ST_OK;
        pidx = 0;
        nidx = 0;
        ox = 0;
        oy = 0;
        case (i_item.opcode)
            OP_MAP: begin
                occ_map[{i_item.cell_col, i_item.cell_row}] = i_item.occupied;
            end
            OP_START: begin
                tree_x[0] = px;
                tree_y[0] = py;
                tree_total = 1;
                iter_cnt = 0;
                run_over = 1'b0;
                goal_x = sx24(i_item.target_x);
                goal_y = sx24(i_item.target_y);
                ox = px;
                oy = py;
            end
            OP_EXTEND: begin
                if (run_over) begin
                    e.status = ST_FINISHED;
                end else if (iter_cnt >= iter_lim) begin
                    e.status = ST_ITER;
                    run_over = 1'b1;
                end else begin
                    iter_cnt++;
                    best = '1;
                    for (int unsigned i = 0; i < tree_total; i++) begin
                        d2 = dist_sq(tree_x[i], tree_y[i], px, py);
                        if (d2 < best) begin
                            best = d2;
                            pidx = i;
                        end
                    end
                    nx = tree_x[pidx];
                    ny = tree_y[pidx];
                    // sample on the nearest node: step along +x
                    if (best == 0) begin
                        offx = step_cfg;
                        offy = 0;
                    end else begin
                        len = root_round(best);
                        offx = div_round((px - nx) * longint'(step_cfg), len);
                        offy = div_round((py - ny) * longint'(step_cfg), len);
                    end
                    ox = clamp24(nx + offx);
                    oy = clamp24(ny + offy);
                    clear = cell_open(ox, oy);
                    n = (probes_cfg == 0) ? 1 : probes_cfg;
                    for (int unsigned i = 1; clear && i <= n; i++) begin
                        qx = nx + div_round((ox - nx) * longint'(i), n);
                        qy = ny + div_round((oy - ny) * longint'(i), n);
                        clear = cell_open(qx, qy);
                    end
                    if (clear) begin
                        nidx = tree_total;
                        tree_x[nidx] = ox;
                        tree_y[nidx] = oy;
                        tree_total++;
                        e.status = ST_ADDED;
                        if (dist_sq(ox, oy, goal_x, goal_y) < tol_cfg) begin
                            e.status = ST_GOAL;
                            run_over = 1'b1;
                        end else if (tree_total >= 4096) begin
                            e.status = ST_POOL;
                            run_over = 1'b1;
                        end
                    end else begin
                        e.status = ST_BLOCKED;
                    end
                    if (!run_over && iter_cnt >= iter_lim) begin
                        e.status = ST_ITER;
                        run_over = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        e.node = nidx[11:0];
        e.parent = pidx[11:0];
        e.x = ox[23:0];
        e.y = oy[23:0];
        e.iters = iter_cnt[15:0];
        branch_q.push_back(e);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic check_branch();
        t_branch e;
        if (branch_q.size() == 0) begin
            report("result with nothing pending, status", i_res.status, 0);
        end else begin
            e = branch_q.pop_front();
            if (i_res.status !== e.status)           report("status", i_res.status, e.status);
            if (i_res.node_index !== e.node)         report("node_index", i_res.node_index, e.node);
            if (i_res.parent_index !== e.parent)     report("parent_index", i_res.parent_index, e.parent);
            if (i_res.new_x !== e.x)                 report("new_x", i_res.new_x, e.x);
            if (i_res.new_y !== e.y)                 report("new_y", i_res.new_y, e.y);
            if (i_res.iterations_used !== e.iters)   report("iterations_used", i_res.iterations_used, e.iters);
        end
    endtask

    initial begin
        fails = 0;
        foreach (occ_map[i]) occ_map[i] = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tree_total = 0;
            iter_cnt = 0;
            run_over = 1'b1;
            goal_x = 0;
            goal_y = 0;
            org_x = 0;
            org_y = 0;
            shift_cfg = DEF_CELL_SHIFT;
            step_cfg = DEF_STEP_SIZE;
            tol_cfg = DEF_GOAL_TOL;
            probes_cfg = DEF_CHECKS;
            iter_lim = DEF_MAX_ITER;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIGIN_X:   org_x = sx24(i_cfg_data[23:0]);
                    CFG_ORIGIN_Y:   org_y = sx24(i_cfg_data[23:0]);
                    CFG_CELL_SHIFT: shift_cfg = i_cfg_data[4:0];
                    CFG_STEP_SIZE:  step_cfg = i_cfg_data[15:0];
                    CFG_GOAL_TOL:   tol_cfg = i_cfg_data[47:0];
                    CFG_CHECKS:     probes_cfg = i_cfg_data[6:0];
                    CFG_MAX_ITER:   iter_lim = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) check_branch();
            if (i_item.valid && i_item.ready) predict_branch();
        end
        o_pending <= branch_q.size();
        o_fails <= fails;
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb import rrt_pkg::*;;

    // spare opcode: the block must answer ok and change nothing
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;

    // quiet: no gaps on either side
    bit                    quiet;
    int                    rx_hold;

    // current planning area, used to aim samples
    longint                area_x, area_y, area_span;

    rrt_in_if  in_ch ();
    rrt_out_if out_ch ();

    rrt_tree_extension dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (in_ch),
        .o_res      (out_ch)
    );

    rrt_tree_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (in_ch),
        .i_res      (out_ch),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: after each accepted result, ready drops for a random stall unless quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_hold <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            automatic int h = quiet ? 0 : $urandom_range(0, 4);
            rx_hold <= h;
            out_ch.ready <= (h == 0);
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            out_ch.ready <= (rx_hold == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic t_coord to_coord(longint v);
        if (v < -64'sd8388608) return COORD_MIN;
        if (v > 64'sd8388607) return COORD_MAX;
        return v[23:0];
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(longint ox, longint oy, int cs, int step, longint unsigned tol,
                           int probes, int iters);
        cfg_write(CFG_ORIGIN_X, 48'(ox));
        cfg_write(CFG_ORIGIN_Y, 48'(oy));
        cfg_write(CFG_CELL_SHIFT, 48'(cs));
        cfg_write(CFG_STEP_SIZE, 48'(step));
        cfg_write(CFG_GOAL_TOL, 48'(tol));
        cfg_write(CFG_CHECKS, 48'(probes));
        cfg_write(CFG_MAX_ITER, 48'(iters));
        cfg_close();
    endtask

    // unused fields carry random bits so every input bit toggles
    task automatic send(logic [1:0] op, longint px, longint py, longint tx, longint ty,
                        logic [7:0] col, logic [7:0] row, logic occ);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.pos_x <= to_coord(px);
        in_ch.pos_y <= to_coord(py);
        in_ch.target_x <= to_coord(tx);
        in_ch.target_y <= to_coord(ty);
        in_ch.cell_col <= col;
        in_ch.cell_row <= row;
        in_ch.occupied <= occ;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic longint any_coord();
        return longint'($signed(24'($urandom)));
    endfunction

    task automatic send_extend(longint px, longint py);
        send(OP_EXTEND, px, py, any_coord(), any_coord(), $urandom, $urandom, $urandom);
    endtask

    task automatic send_start(longint px, longint py, longint tx, longint ty);
        send(OP_START, px, py, tx, ty, $urandom, $urandom, $urandom);
    endtask

    task automatic send_map(logic [7:0] col, logic [7:0] row, logic occ);
        send(OP_MAP, any_coord(), any_coord(), any_coord(), any_coord(), col, row, occ);
    endtask

    // wait for every result, then let the block settle before a register write
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic longint near_area();
        return longint'($urandom_range(0, 2 * 32'(area_span))) - area_span;
    endfunction

    // mostly well-formed extends aimed at the current tree, some noise
    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            if ($urandom_range(0, 9) == 0)
                send_extend(any_coord(), any_coord());
            else
                send_extend(area_x + near_area(), area_y + near_area());
        end else if (pick < 85) begin
            send_map($urandom, $urandom, $urandom_range(0, 3) == 0);
        end else if (pick < 92) begin
            send_start(area_x + near_area(), area_y + near_area(),
                       area_x + near_area(), area_y + near_area());
        end else begin
            send(OP_SPARE, any_coord(), any_coord(), any_coord(), any_coord(),
                 $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        longint ox, oy, tol;
        int     cs, step, probes, iters;

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_MAP;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.cell_col = '0;
        in_ch.cell_row = '0;
        in_ch.occupied = 1'b0;
        quiet = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grid cells are undefined until written: clear the whole map first
        for (int c = 0; c < 256; c++)
            for (int r = 0; r < 256; r++)
                send_map(c, r, 1'b0);
        drain();
        quiet = 1'b0;

        // directed: 1.0 unit cells from the origin
        cfg_all(0, 0, 10, 2048, 1 << 20, 4, 5000);
        send_extend(1000, 1000);                     // run not started: finished
        send(OP_SPARE, -1, -1, -1, -1, 8'hFF, 8'hFF, 1'b1);
        send_map(8'hFF, 8'hFF, 1'b1);
        send_map(8'h00, 8'h00, 1'b1);
        send_map(8'd22, 8'd20, 1'b1);
        send_start(20480, 20480, 28480, 20480);
        send_extend(20480, 20480);                   // sample on root steps +x
        send_extend(20480, 30000);
        send_extend(COORD_MIN, COORD_MIN);
        send_extend(COORD_MAX, COORD_MAX);
        send_extend(COORD_MAX, COORD_MIN);
        send_start(100, 100, COORD_MAX, COORD_MAX);
        send_extend(-100000, 100);                   // steps off the grid
        send_extend(100, 60000);
        send_start(20000, 20000, 20500, 20000);      // goal closer than one step; the step lands outside the tolerance
        send_extend(30000, 20000);
        send_extend(30000, 20000);                   // steps on past the goal: added
        drain();
        cfg_all(0, 0, 10, 2048, 0, 4, 2);
        send_start(50000, 50000, 0, 0);
        send_extend(60000, 50000);
        send_extend(60000, 50000);                   // hits the iteration limit
        send_extend(60000, 50000);
        drain();
        cfg_all(0, 0, 10, 2048, 0, 4, 0);
        send_start(50000, 50000, 0, 0);
        send_extend(60000, 50000);                   // limit already reached

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            quiet = (ph == 3);
            case (ph)
                0: begin
                    ox = COORD_MIN; oy = COORD_MIN; cs = 20; step = 65535;
                    tol = 48'hFFFF_FFFF_FFFF; probes = 64; iters = 65535;
                end
                1: begin
                    ox = COORD_MAX; oy = COORD_MAX; cs = 0; step = 0;
                    tol = 0; probes = 0; iters = 0;
                end
                default: begin
                    cs = $urandom_range(4, 12);
                    ox = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
                    oy = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
                    step = $urandom_range(1, 6 << cs);
                    tol = longint'($urandom_range(0, 400)) << (2 * cs);
                    probes = (ph == 2) ? 127 : $urandom_range(1, 64);
                    iters = $urandom_range(15, 60);
                end
            endcase
            cfg_all(ox, oy, cs, step, tol, probes, iters);
            if (ph == 0) begin
                area_span = 1 << 22;
                area_x = 0;
                area_y = 0;
            end else begin
                area_span = 40 << cs;
                area_x = ox + (longint'($urandom_range(20, 230)) << cs);
                area_y = oy + (longint'($urandom_range(20, 230)) << cs);
            end
            send_start(area_x, area_y, area_x + near_area(), area_y + near_area());
            repeat (23) random_item();
        end

        drain();
        repeat (1000) @(posedge i_clk);
        if (fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
